/* hw/rtl/pno2d_pkg.sv */
// pno2d_pkg: shared types and constants for the octave noise unit
// no dependencies
`timescale 1ns / 1ps

package pno2d_pkg;

    localparam int PermEntries = 256;
    localparam int PermAw      = $clog2(PermEntries);
    localparam int MaxOctaves  = 16;

    localparam logic [0:0] CfgOctaves = 1'b0;
    localparam logic [0:0] CfgPersist = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_X0, ST_RD_X1, ST_RD_A0, ST_RD_A1, ST_RD_B0, ST_RD_B1,
        ST_RD_AA, ST_RD_AB, ST_RD_BA, ST_RD_BB, ST_GRAD,
        ST_FADE, ST_LERP, ST_ACC, ST_DIV, ST_OUT
    } state_t;

endpackage

/* hw/rtl/pno2d_mul.sv */
// pno2d_mul: shared 33x33 signed multiplier with registered product
// depends on pno2d_pkg
`timescale 1ns / 1ps

module pno2d_mul
    import pno2d_pkg::*;
(
    input  logic               aclk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] prod_reg
);

    // one product per cycle, registered
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

/* hw/rtl/perlin_noise_octave_2d_unit.sv */
// perlin_noise_octave_2d_unit: top level of the multi-octave gradient noise unit
// depends on pno2d_pkg and pno2d_mul
//
//  channel  ports                                  direction
//  input    s_valid s_ready s_mode .. s_coord_y    in
//  result   m_valid m_ready m_noise_value          out
//  config   cfg_we cfg_index cfg_wdata             in
//
// a load word writes one table entry; an evaluate word runs, for each octave, the
// table reads, the gradient, fade, lerp and accumulate steps, then the division
// and the output state, which raises m_valid; the next word is taken only back in
// idle. The steps share the multiplier and the single table read port under the
// sequencer.
// reset is synchronous; the table is undefined until loaded.
// a waiting result holds the next one in the output state; words are taken only when idle.
`timescale 1ns / 1ps

module perlin_noise_octave_2d_unit
    import pno2d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_perm_index,
    input  logic [7:0]  s_perm_value,
    input  logic [31:0] s_coord_x,
    input  logic [31:0] s_coord_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_noise_value,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [7:0] perm_mem [PermEntries];
    logic [PermAw-1:0] rd_addr;
    logic [7:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [4:0]  oct_cfg_reg;
    logic [15:0] pers_reg;
    logic [31:0] cx_reg, cy_reg;
    logic [4:0]  oct_left_reg;
    logic [7:0]  pa_reg, pb_reg;
    logic [7:0]  h_reg [4];
    logic signed [27:0] g_reg [4];
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [3:0] step_reg;
    logic [25:0] t2_reg, t3_reg, u_reg, v_reg;
    logic signed [27:0] l0_reg, l1_reg, res_reg;
    logic signed [49:0] sum_reg;
    logic [31:0] amp_reg;
    logic [32:0] amp_sum_reg;
    logic [50:0] rem_reg;
    logic [50:0] dsh_reg;
    logic [16:0] quo_reg;
    logic [4:0]  div_cnt_reg;
    logic [15:0] out_reg;
    logic        mval_reg;
    logic        out_load;

    logic [23:0] fx, fy, fsel;
    logic [28:0] fade_q;
    logic signed [19:0] oct_val;

    assign fx = cx_reg[23:0];
    assign fy = cy_reg[23:0];

    // fade works on x in its first half and on y in its second
    assign fsel   = (step_reg < 4'd6) ? fx : fy;
    assign fade_q = 29'(t2_reg) * 29'd6 + (29'd10 << 24) - 29'(fsel) * 29'd15;

    // (v+1)/2 of one octave in q.17
    assign oct_val = 20'((res_reg + 28'sd33554432) >>> 8) - 20'sd65536;

    // gradient selection for improved noise, z = 0
    function automatic logic signed [27:0] grad2(input logic [3:0] h,
            input logic signed [27:0] x, input logic signed [27:0] y);
        logic signed [27:0] gu, gv;
        gu = (h < 4'd8) ? x : y;
        gv = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : 28'sd0);
        return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    endfunction

    // table memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && !s_mode) begin
            perm_mem[s_perm_index] <= s_perm_value;
        end
        rd_data_reg <= perm_mem[rd_addr];
    end

    pno2d_mul u_mul (.aclk(aclk), .op_a(mul_a), .op_b(mul_b), .prod_reg(prod));

    assign out_load      = (state_reg == ST_OUT) && (!mval_reg || m_ready);
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = mval_reg;
    assign m_noise_value = out_reg;

    // read address per sequencer state; data is seen one state later
    always_comb begin
        unique case (state_reg)
            ST_RD_X0: rd_addr = cx_reg[31:24];
            ST_RD_X1: rd_addr = cx_reg[31:24] + 8'd1;
            ST_RD_A0: rd_addr = pa_reg;
            ST_RD_A1: rd_addr = pa_reg + 8'd1;
            ST_RD_B0: rd_addr = pb_reg;
            ST_RD_B1: rd_addr = pb_reg + 8'd1;
            ST_RD_AA: rd_addr = h_reg[0];
            ST_RD_AB: rd_addr = h_reg[1];
            ST_RD_BA: rd_addr = h_reg[2];
            ST_RD_BB: rd_addr = h_reg[3];
            default:  rd_addr = '0;
        endcase
    end

    // multiplier operand selection per step
    always_comb begin
        logic signed [27:0] da;
        mul_a = '0;
        mul_b = '0;
        da = '0;
        unique case (state_reg)
            ST_FADE: begin
                unique case (step_reg)
                    4'd0, 4'd6:  begin mul_a = 33'(fsel); mul_b = 33'(fsel); end
                    4'd2, 4'd8:  begin mul_a = 33'(t2_reg); mul_b = 33'(fsel); end
                    4'd4, 4'd10: begin mul_a = 33'(t3_reg); mul_b = 33'(fade_q); end
                    default: ;
                endcase
            end
            ST_LERP: begin
                unique case (step_reg)
                    4'd0: begin da = g_reg[1] - g_reg[0]; mul_a = 33'(da); mul_b = 33'(u_reg); end
                    4'd2: begin da = g_reg[3] - g_reg[2]; mul_a = 33'(da); mul_b = 33'(u_reg); end
                    4'd4: begin da = l1_reg - l0_reg; mul_a = 33'(da); mul_b = 33'(v_reg); end
                    default: ;
                endcase
            end
            ST_ACC: begin
                unique case (step_reg)
                    4'd0: begin mul_a = 33'(oct_val); mul_b = 33'(amp_reg); end
                    4'd1: begin mul_a = 33'(amp_reg); mul_b = 33'(pers_reg); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // truncate toward zero after >> 24
    function automatic logic signed [27:0] tz24(input logic signed [65:0] p);
        logic [65:0] m;
        logic [65:0] q;
        m = p[65] ? 66'(-p) : 66'(p);
        q = m >> 24;
        return p[65] ? -28'(q) : 28'(q);
    endfunction

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid && s_ready && s_mode) state_next = ST_RD_X0;
            ST_RD_X0: state_next = ST_RD_X1;
            ST_RD_X1: state_next = ST_RD_A0;
            ST_RD_A0: state_next = ST_RD_A1;
            ST_RD_A1: state_next = ST_RD_B0;
            ST_RD_B0: state_next = ST_RD_B1;
            ST_RD_B1: state_next = ST_RD_AA;
            ST_RD_AA: state_next = ST_RD_AB;
            ST_RD_AB: state_next = ST_RD_BA;
            ST_RD_BA: state_next = ST_RD_BB;
            ST_RD_BB: state_next = ST_GRAD;
            ST_GRAD:  state_next = ST_FADE;
            ST_FADE:  if (step_reg == 4'd11) state_next = ST_LERP;
            ST_LERP:  if (step_reg == 4'd5) state_next = ST_ACC;
            ST_ACC:   if (step_reg == 4'd2) state_next = (oct_left_reg == 5'd1) ? ST_DIV : ST_RD_X0;
            ST_DIV:   if (div_cnt_reg == 5'd0) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            oct_cfg_reg <= 5'd4;
            pers_reg    <= 16'd32768;
            mval_reg    <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg <= state_next;
            // configuration writes
            if (cfg_we) begin
                if (cfg_index == CfgOctaves)      oct_cfg_reg <= cfg_wdata[4:0];
                else if (cfg_index == CfgPersist) pers_reg    <= cfg_wdata;
            end
            if (out_load)     mval_reg <= 1'b1;
            else if (m_ready) mval_reg <= 1'b0;
            if (state_next != state_reg) step_reg <= '0;
            else step_reg <= step_reg + 4'd1;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                cx_reg <= s_coord_x;
                cy_reg <= s_coord_y;
                sum_reg <= '0;
                amp_reg <= 32'd65536;
                amp_sum_reg <= '0;
                if (oct_cfg_reg == 5'd0) oct_left_reg <= 5'd1;
                else if (oct_cfg_reg > 5'(MaxOctaves)) oct_left_reg <= 5'(MaxOctaves);
                else oct_left_reg <= oct_cfg_reg;
            end
            ST_RD_X1: pa_reg <= rd_data_reg + cy_reg[31:24];
            ST_RD_A0: pb_reg <= rd_data_reg + cy_reg[31:24];
            ST_RD_A1: h_reg[0] <= rd_data_reg;
            ST_RD_B0: h_reg[1] <= rd_data_reg;
            ST_RD_B1: h_reg[2] <= rd_data_reg;
            ST_RD_AA: h_reg[3] <= rd_data_reg;
            ST_RD_AB: g_reg[0] <= grad2(rd_data_reg[3:0], 28'(fx), 28'(fy));
            ST_RD_BA: g_reg[2] <= grad2(rd_data_reg[3:0], 28'(fx), 28'(fy) - 28'sd16777216);
            ST_RD_BB: g_reg[1] <= grad2(rd_data_reg[3:0], 28'(fx) - 28'sd16777216, 28'(fy));
            ST_GRAD:  g_reg[3] <= grad2(rd_data_reg[3:0], 28'(fx) - 28'sd16777216,
                                        28'(fy) - 28'sd16777216);
            ST_FADE: begin
                unique case (step_reg)
                    4'd1, 4'd7: t2_reg <= 26'(prod >>> 24);
                    4'd3, 4'd9: t3_reg <= 26'(prod >>> 24);
                    4'd5:       u_reg  <= 26'(prod >>> 24);
                    4'd11:      v_reg  <= 26'(prod >>> 24);
                    default: ;
                endcase
            end
            ST_LERP: begin
                unique case (step_reg)
                    4'd1: l0_reg  <= g_reg[0] + tz24(prod);
                    4'd3: l1_reg  <= g_reg[2] + tz24(prod);
                    4'd5: res_reg <= l0_reg + tz24(prod);
                    default: ;
                endcase
            end
            ST_ACC: begin
                unique case (step_reg)
                    4'd1: begin
                        sum_reg     <= sum_reg + 50'(prod);
                        amp_sum_reg <= amp_sum_reg + 33'(amp_reg);
                    end
                    4'd2: begin
                        amp_reg      <= 32'(prod >>> 15);
                        cx_reg       <= cx_reg << 1;
                        cy_reg       <= cy_reg << 1;
                        oct_left_reg <= oct_left_reg - 5'd1;
                        // divider set-up, used after the last octave
                        rem_reg      <= sum_reg[49] ? '0 : 51'($unsigned(sum_reg));
                        dsh_reg      <= 51'(amp_sum_reg) << 17;
                        div_cnt_reg  <= 5'd16;
                    end
                    default: ;
                endcase
            end
            // restoring division, top bit flags saturation
            ST_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    quo_reg <= {quo_reg[15:0], 1'b1};
                end else begin
                    quo_reg <= {quo_reg[15:0], 1'b0};
                end
                dsh_reg     <= dsh_reg >> 1;
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            ST_OUT: if (out_load) out_reg <= quo_reg[16] ? 16'hFFFF : quo_reg[15:0];
            default: ;
        endcase
    end

    // result held steady while it waits
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_noise_value));

    // input taken only when idle
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE);

    // no result straight after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid);

    // an octave is pending while accumulating
    a_oct: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACC |-> oct_left_reg != 5'd0);

endmodule
